@@ rtl/rsa_pkg.sv @@
// rsa_pkg: word types and command codes for the RPN stack calculator.
// No dependencies; included by wildcard import in every rtl module.
package rsa_pkg;

  localparam logic [3:0] CMD_PUSH = 4'd0;
  localparam logic [3:0] CMD_ADD  = 4'd1;
  localparam logic [3:0] CMD_SUB  = 4'd2;
  localparam logic [3:0] CMD_MUL  = 4'd3;
  localparam logic [3:0] CMD_DIV  = 4'd4;
  localparam logic [3:0] CMD_AND  = 4'd5;
  localparam logic [3:0] CMD_OR   = 4'd6;
  localparam logic [3:0] CMD_SHL  = 4'd7;
  localparam logic [3:0] CMD_SHR  = 4'd8;
  localparam logic [3:0] CMD_SHOW = 4'd9;
  localparam logic [3:0] CMD_DUMP = 4'd10;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] word_out;
    logic [1:0]  level_index;
    logic        last_word;
    logic        divide_error;
  } out_word_t;

  // Request from the sequencer to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic div;
  } md_req_t;

endpackage

@@ rtl/rsa_muldiv.sv @@
// rsa_muldiv: shared iterative multiply (low word) and restoring divide unit.
// Depends on rsa_pkg for the request struct.
module rsa_muldiv #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rsa_pkg::md_req_t   req,
  input  logic [WIDTH-1:0]   opa,
  input  logic [WIDTH-1:0]   opb,
  output logic               done,
  output logic [WIDTH-1:0]   result
);
  import rsa_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             div_r, div_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;

  // One adder serves both operations; subtract for the divide trial.
  logic [WIDTH:0] add_a;
  logic [WIDTH:0] add_b;
  logic           add_sub;
  logic [WIDTH:0] sum;

  always_comb begin
    if (div_r) begin
      add_a   = {acc_r, q_r[WIDTH-1]};
      add_sub = 1'b1;
    end else begin
      add_a   = {1'b0, acc_r};
      add_sub = 1'b0;
    end
    add_b = {1'b0, b_r};
    sum   = add_a + (add_sub ? ~add_b : add_b) + (WIDTH+1)'(add_sub);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.div;
      cnt_nxt  = CW'(WIDTH);
      acc_nxt  = '0;
      q_nxt    = opa;
      b_nxt    = opb;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (div_r) begin
        if (!sum[WIDTH]) begin
          acc_nxt = sum[WIDTH-1:0];
          q_nxt   = {q_r[WIDTH-2:0], 1'b1};
        end else begin
          acc_nxt = add_a[WIDTH-1:0];
          q_nxt   = {q_r[WIDTH-2:0], 1'b0};
        end
      end else begin
        if (q_r[0]) begin
          acc_nxt = sum[WIDTH-1:0];
        end
        q_nxt = q_r >> 1;
        b_nxt = b_r << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    b_r   <= b_nxt;
  end

  assign done   = done_r;
  assign result = div_r ? q_r : acc_r;

endmodule

@@ rtl/rpn_stack_alu.sv @@
// rpn_stack_alu: RPN stack calculator, top level with stack and sequencer.
// Push, add, sub, and, or and shifts write the stack when accepted; mul and div
// run one bit per cycle in the shared unit, then write the top; show presents
// the top word, dump presents STACK_DEPTH words, one per cycle when out_ready
// is high. A new word is taken only in the idle state.
// Reset (rst_n low, synchronous) clears the stack, the error flag and all control.
module rpn_stack_alu #(
  parameter int STACK_DEPTH = 4,
  parameter int WORD_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsa_pkg::out_word_t out_data
);
  import rsa_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH);

  // The sequencer is idle, waits on the multiply/divide unit, or walks the
  // stack levels for a show or a dump.
  typedef enum logic [1:0] {
    S_IDLE,
    S_MULDIV,
    S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [WORD_WIDTH-1:0] stk_r   [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] stk_nxt [STACK_DEPTH];
  logic                  err_r, err_nxt;
  logic [LW-1:0]         lvl_r, lvl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  md_req_t               md_req;
  logic                  md_done;
  logic [WORD_WIDTH-1:0] md_result;

  logic [WORD_WIDTH-1:0] x_word;
  logic [WORD_WIDTH-1:0] y_word;

  // X is the popped top, Y the word beneath it which becomes the new top.
  assign x_word = stk_r[0];
  assign y_word = stk_r[1];

  rsa_muldiv #(
    .WIDTH (WORD_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .opa    (y_word),
    .opb    (x_word),
    .done   (md_done),
    .result (md_result)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    stk_nxt       = stk_r;
    err_nxt       = err_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    md_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.command)
            CMD_PUSH: begin
              // Lift: every level moves down one, the bottom word falls off.
              for (int i = 1; i < STACK_DEPTH; i++) begin
                stk_nxt[i] = stk_r[i-1];
              end
              stk_nxt[0] = WORD_WIDTH'(in_data.operand_value);
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_AND, CMD_OR: begin
              // Drop: levels move up, the bottom level keeps its word.
              for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                stk_nxt[i] = stk_r[i+1];
              end
              case (in_data.command)
                CMD_ADD: stk_nxt[0] = y_word + x_word;
                CMD_SUB: stk_nxt[0] = y_word - x_word;
                CMD_AND: stk_nxt[0] = y_word & x_word;
                CMD_OR:  stk_nxt[0] = y_word | x_word;
                default: begin
                  // Multiply and divide run in the shared unit; a zero
                  // divisor yields all ones there and sets the sticky flag.
                  md_req.start = 1'b1;
                  md_req.div   = (in_data.command == CMD_DIV);
                  if (in_data.command == CMD_DIV && x_word == '0) begin
                    err_nxt = 1'b1;
                  end
                  state_nxt = S_MULDIV;
                end
              endcase
            end
            CMD_SHL: stk_nxt[0] = stk_r[0] << 1;
            CMD_SHR: stk_nxt[0] = stk_r[0] >> 1;
            CMD_SHOW: begin
              lvl_nxt   = '0;
              state_nxt = S_EMIT;
            end
            CMD_DUMP: begin
              lvl_nxt   = LW'(STACK_DEPTH - 1);
              state_nxt = S_EMIT;
            end
            default: ;  // Unused codes leave the stack alone.
          endcase
        end
      end
      S_MULDIV: begin
        if (md_done) begin
          stk_nxt[0] = md_result;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT: begin
        // One level per free output slot, bottom first for a dump.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.word_out     = 32'(stk_r[lvl_r]);
          out_data_nxt.level_index  = 2'(lvl_r);
          out_data_nxt.last_word    = (lvl_r == '0);
          out_data_nxt.divide_error = err_r;
          if (lvl_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt = lvl_r - 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      err_r       <= 1'b0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
      stk_r       <= stk_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for the rpn_stack_alu four-level RPN calculator.
// Depends on rsa_pkg (command codes, word structs) and rtl/rpn_stack_alu.sv.
// A directed command list runs first, then a random but well-formed command stream.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsa_pkg::*;

  localparam int NUM_LEVELS   = 4;
  localparam int RANDOM_CMDS  = 232;
  localparam int MAX_GAP      = 4;
  // Multiply and divide are the slowest commands; this margin covers any
  // command still in flight once the last result word has come out.
  localparam int DRAIN_CYCLES = 40;
  // About 270 commands, each with its idle gap, busy time and up to four result
  // words behind receiver stalls, bound the run; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // Codes 11 through 15 have no meaning and must be swallowed silently.
  localparam logic [3:0] CMD_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  rpn_stack_alu #(
    .STACK_DEPTH(NUM_LEVELS),
    .WORD_WIDTH (32)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Period of 2 ns: one delay high, one delay low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the stack and the sticky divide error
  // flag, and turns every accepted command word into the result words that
  // the calculator has to produce for it.
  // ---------------------------------------------------------------------------
  logic [31:0] stack_model [NUM_LEVELS] = '{default: '0};
  logic        div_error_model = 1'b0;
  out_word_t   expected_words [$];

  int shows_seen    = 0;
  int dumps_seen    = 0;
  int ignored_seen  = 0;
  int div_by_zero   = 0;

  function automatic out_word_t level_word(int level, logic last);
    out_word_t w;
    w.word_out     = stack_model[level];
    w.level_index  = level[1:0];
    w.last_word    = last;
    w.divide_error = div_error_model;
    return w;
  endfunction

  function automatic void predict_command(in_word_t cmd_word);
    logic [31:0] x;
    logic [31:0] y;
    case (cmd_word.command)
      CMD_PUSH: begin
        // Lift: the bottom level falls off and the operand lands on top.
        for (int i = NUM_LEVELS - 1; i > 0; i--) stack_model[i] = stack_model[i - 1];
        stack_model[0] = cmd_word.operand_value;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_AND, CMD_OR: begin
        // Pop X; the drop leaves the bottom level in place, so it is doubled.
        x = stack_model[0];
        for (int i = 0; i < NUM_LEVELS - 1; i++) stack_model[i] = stack_model[i + 1];
        y = stack_model[0];
        case (cmd_word.command)
          CMD_ADD: y = y + x;
          CMD_SUB: y = y - x;
          CMD_MUL: y = y * x;
          CMD_DIV: begin
            // Division by zero saturates the quotient and latches the error
            // flag until the next reset.
            if (x == '0) begin
              y = '1;
              div_error_model = 1'b1;
              div_by_zero++;
            end else begin
              y = y / x;
            end
          end
          CMD_AND: y = y & x;
          default: y = y | x;
        endcase
        stack_model[0] = y;
      end
      CMD_SHL: stack_model[0] = stack_model[0] << 1;
      CMD_SHR: stack_model[0] = stack_model[0] >> 1;
      CMD_SHOW: begin
        expected_words.push_back(level_word(0, 1'b1));
        shows_seen++;
      end
      CMD_DUMP: begin
        // Bottom level first; only the top level carries the last flag.
        for (int lvl = NUM_LEVELS - 1; lvl >= 0; lvl--) begin
          expected_words.push_back(level_word(lvl, lvl == 0));
        end
        dumps_seen++;
      end
      default: ignored_seen++;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command source. The initial block below fills this queue before reset is
  // released; the driver takes from it one word at a time.
  // ---------------------------------------------------------------------------
  in_word_t pending_commands [$];

  function automatic void queue_command(logic [3:0] cmd, logic [31:0] value);
    in_word_t w;
    w.command       = cmd;
    w.operand_value = value;
    pending_commands.push_back(w);
  endfunction

  // Operands lean toward the corners: zero, all ones, single bits and tiny
  // values, with fully random words for the rest.
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'($urandom_range(0, 15));
      3:       return 32'b1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Port sampling at the rising edge: acceptance of command words feeds the
  // predictor, acceptance of result words is checked against the oldest
  // expectation. Both flags below tell the falling-edge drivers what happened.
  // ---------------------------------------------------------------------------
  logic in_accepted = 1'b0;
  logic out_taken   = 1'b0;
  int   cycle_count = 0;
  int   words_sent  = 0;
  int   words_checked = 0;
  int   mismatches  = 0;

  always @(posedge clk) begin
    out_word_t expected;
    cycle_count <= cycle_count + 1;
    in_accepted <= rst_n && in_valid && in_ready;
    out_taken   <= rst_n && out_valid && out_ready;

    if (rst_n && in_valid && in_ready) begin
      predict_command(in_data);
      words_sent++;
    end

    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR: unexpected result word %h level %0d last %0b err %0b",
                   out_data.word_out, out_data.level_index, out_data.last_word,
                   out_data.divide_error);
        end
      end else begin
        expected = expected_words.pop_front();
        if (out_data.word_out     !== expected.word_out    ||
            out_data.level_index  !== expected.level_index ||
            out_data.last_word    !== expected.last_word   ||
            out_data.divide_error !== expected.divide_error) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display({"ERROR: result %0d expected word %h level %0d last %0b err %0b,",
                      " got word %h level %0d last %0b err %0b"},
                     words_checked, expected.word_out, expected.level_index,
                     expected.last_word, expected.divide_error, out_data.word_out,
                     out_data.level_index, out_data.last_word, out_data.divide_error);
          end
        end
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver, falling edge. A word stays on the bus until it is taken.
  // Between words it waits a freshly drawn random gap, at most MAX_GAP, except in burst
  // stretches where it keeps valid high back to back. The next valid level is
  // worked out first so that valid gets exactly one update per edge.
  // ---------------------------------------------------------------------------
  int in_gap   = 0;
  bit in_burst = 1'b0;

  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (rst_n) begin
      if (in_accepted) next_valid = 1'b0;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_commands.size() != 0) begin
          in_data <= pending_commands.pop_front();
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Result receiver, falling edge. After each word taken it may hold ready
  // low for a random stall of at most MAX_GAP, so stalls land in the middle of dumps as well.
  int out_stall = 0;
  bit out_burst = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake or a missing result word ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("ERROR: no completion after %0d cycles", CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [3:0] cmd;
    int         pick;
    int         counted;

    // Directed part. The stack and the error flag are clear after reset.
    queue_command(CMD_SHOW, $urandom);
    queue_command(CMD_DUMP, $urandom);
    // All ones plus one wraps to zero.
    queue_command(CMD_PUSH, '1);
    queue_command(CMD_PUSH, 32'd1);
    queue_command(CMD_ADD,  $urandom);
    // Zero minus one wraps to all ones, then the top is halved.
    queue_command(CMD_PUSH, 32'd1);
    queue_command(CMD_SUB,  $urandom);
    queue_command(CMD_SHR,  $urandom);
    // The top bit falls off the left end.
    queue_command(CMD_PUSH, 32'h8000_0000);
    queue_command(CMD_SHL,  $urandom);
    // Only the low word of the product is kept: all ones squared gives one.
    queue_command(CMD_PUSH, '1);
    queue_command(CMD_PUSH, '1);
    queue_command(CMD_MUL,  $urandom);
    queue_command(CMD_PUSH, $urandom);
    queue_command(CMD_PUSH, 32'd3);
    queue_command(CMD_DIV,  $urandom);
    queue_command(CMD_PUSH, $urandom);
    queue_command(CMD_AND,  $urandom);
    // This pop reaches the duplicated bottom level.
    queue_command(CMD_OR,   $urandom);
    queue_command(CMD_DUMP, $urandom);
    // Unused codes at both ends of the spare range.
    queue_command(CMD_FIRST_UNUSED, $urandom);
    queue_command(CMD_LAST_UNUSED,  $urandom);
    // Division by zero; the error flag stays set from here on.
    queue_command(CMD_PUSH, '0);
    queue_command(CMD_DIV,  $urandom);
    queue_command(CMD_DUMP, $urandom);

    // Random part. Every command is legal on a four-level stack, so the mix
    // mostly follows how the calculator is used: pushes feeding operations,
    // with shows and dumps to expose the state. Unused codes are sprinkled in
    // but are not counted. Operands on non-push words are noise to ignore.
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd = CMD_PUSH;
      else if (pick < 56) cmd = 4'($urandom_range(CMD_ADD, CMD_OR));
      else if (pick < 64) cmd = ($urandom_range(0, 1) == 0) ? CMD_SHL : CMD_SHR;
      else if (pick < 74) cmd = CMD_SHOW;
      else if (pick < 82) cmd = CMD_DUMP;
      else if (pick < 87) cmd = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      else                cmd = CMD_PUSH;
      queue_command(cmd, random_operand());
      if (cmd < CMD_FIRST_UNUSED) counted++;
    end

    // Reset is held low at first and released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last command word to be taken, then for its results.
    while (pending_commands.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_words.size() != 0) begin
      $display("ERROR: %0d expected result words never arrived", expected_words.size());
      mismatches += expected_words.size();
    end

    $display({"Sent %0d command words: %0d shows, %0d dumps, %0d unused codes,",
              " %0d divides by zero."},
             words_sent, shows_seen, dumps_seen, ignored_seen, div_by_zero);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
